FILE: hw/rtl/sorted_key_set_defines.svh
// assertion macros for the sorted key set
`ifndef SORTED_KEY_SET_DEFINES_SVH
`define SORTED_KEY_SET_DEFINES_SVH

// same-cycle implication, checked on every clk edge out of reset
`define SKS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_set check failed");

// next-cycle implication
`define SKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_set check failed");

`endif

FILE: hw/rtl/skset_pkg.sv
// shared constants, codes and cell control type for the sorted key set
`timescale 1ns / 1ps
package skset_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int KEY_PORT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RM_MIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RM_MAX  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RM_KEY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd3;

  typedef struct packed {
    logic load_cmp;   // latch compare flags against the incoming key
    logic ins;        // open a slot at the insert position
    logic shl_all;    // every cell takes its right neighbor
    logic shl_pos;    // cells at or above the match take their right neighbor
    logic pick_eq;    // matching cell drives its key onto the pick bus
    logic pick_last;  // last occupied cell drives its key onto the pick bus
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/skset_cell.sv
// one storage cell of the key chain: a key, its compare flags and shift muxing
`timescale 1ns / 1ps
module skset_cell #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32,
  parameter int IDX       = 0
) (
  input  logic                           clk,
  input  skset_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic [KEY_WIDTH-1:0]           cmp_key,
  input  logic [KEY_WIDTH-1:0]           ins_key,
  input  logic [KEY_WIDTH-1:0]           left_key,
  input  logic                           left_lt,
  input  logic [KEY_WIDTH-1:0]           right_key,
  output logic [KEY_WIDTH-1:0]           key_q,
  output logic                           lt_q,
  output logic                           eq_q,
  output logic [KEY_WIDTH-1:0]           pick_key
);
  import skset_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 lt_r, eq_r;
  logic                 occ, last;

  assign occ  = CNT_W'(IDX) < count;
  assign last = CNT_W'(IDX + 1) == count;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins && !lt_r) begin
      // first cell not below the key takes it, the rest shift up
      key_nxt = left_lt ? ins_key : left_key;
    end else if (ctrl.shl_all || (ctrl.shl_pos && !lt_r)) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctrl.load_cmp) begin
      lt_r <= occ && ($signed(key_r) < $signed(cmp_key));
      eq_r <= occ && (key_r == cmp_key);
    end
  end

  assign key_q    = key_r;
  assign lt_q     = lt_r;
  assign eq_q     = eq_r;
  assign pick_key = ((ctrl.pick_eq && eq_r) || (ctrl.pick_last && last)) ? key_r : '0;

endmodule

FILE: hw/rtl/sorted_key_set.sv
// sorted key set top: command decode, key count and a chain of DEPTH key cells
// the accepting edge latches the compare flags, the update-state edge registers out_valid
// a new word is taken only while idle; busy is high for the update cycle only
// the result register is loaded as the chain updates, so a new word may start
// while the previous result is on the ports; the receiver cannot stall
// reset (synchronous, rst_n low) empties the set; stored keys are not cleared
`timescale 1ns / 1ps
`include "sorted_key_set_defines.svh"
module sorted_key_set #(
  parameter int DEPTH     = skset_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skset_pkg::KEY_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [skset_pkg::MODE_W-1:0]     in_mode,
  input  logic [skset_pkg::KEY_PORT_W-1:0] in_key,
  output logic                             out_valid,
  output logic [skset_pkg::STATUS_W-1:0]   out_status,
  output logic [skset_pkg::KEY_PORT_W-1:0] out_removed_key,
  output logic [skset_pkg::OCC_W-1:0]      out_occupancy
);
  import skset_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] in_key_w;
  logic                 accept;
  logic                 held;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r, status_nxt;
  logic [KEY_PORT_W-1:0] out_removed_key_r;
  logic [OCC_W-1:0]     out_occupancy_r;
  logic [KEY_WIDTH-1:0] removed_nxt;
  logic [KEY_WIDTH-1:0] pick_or;

  logic [KEY_WIDTH+KEY_PORT_W-1:0] in_key_ext;
  logic [KEY_WIDTH+KEY_PORT_W-1:0] rem_ext;
  logic [CNT_W+OCC_W-1:0]          occ_ext;

  cell_ctrl_t           ctrl;
  logic [DEPTH-1:0]     lt_v, eq_v;
  logic [KEY_WIDTH-1:0] key_v  [DEPTH];
  logic [KEY_WIDTH-1:0] pick_v [DEPTH];

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r == S_UPD);
  assign in_key_ext = {{KEY_WIDTH{1'b0}}, in_key};
  assign in_key_w   = in_key_ext[KEY_WIDTH-1:0];
  assign held       = |eq_v;

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_or = pick_or | pick_v[i];
    end
  end

  // decode: compare load on accept, chain control and results in the update cycle
  always_comb begin
    ctrl           = '0;
    ctrl.load_cmp  = accept;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    removed_nxt    = '0;
    state_nxt      = accept ? S_UPD : S_IDLE;
    if (state_r == S_UPD) begin
      ctrl.pick_eq   = (mode_r == MODE_RM_KEY);
      ctrl.pick_last = (mode_r == MODE_RM_MAX);
      case (mode_r)
        MODE_INSERT: begin
          if (held) begin
            status_nxt = ST_DUP;
          end else if (count_r == CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = CNT_W'(count_r + 1'b1);
          end
        end
        MODE_RM_MIN: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.shl_all = 1'b1;
            removed_nxt  = key_v[0];
            count_nxt    = CNT_W'(count_r - 1'b1);
          end
        end
        MODE_RM_MAX: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            removed_nxt = pick_or;
            count_nxt   = CNT_W'(count_r - 1'b1);
          end
        end
        MODE_RM_KEY: begin
          if (held) begin
            ctrl.shl_pos = 1'b1;
            removed_nxt  = pick_or;
            count_nxt    = CNT_W'(count_r - 1'b1);
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        MODE_QUERY: begin
          status_nxt = held ? ST_OK : ST_EMPTY;
        end
        MODE_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign rem_ext = {{KEY_PORT_W{1'b0}}, removed_nxt};
  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r  <= in_key_w;
    end
    if (state_r == S_UPD) begin
      out_status_r      <= status_nxt;
      out_removed_key_r <= rem_ext[KEY_PORT_W-1:0];
      out_occupancy_r   <= occ_ext[OCC_W-1:0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key, right_key;
      logic                 left_lt;
      if (g == 0) begin : g_first
        // nothing sits left of the head, so it takes the new key whenever its own key is not below it
        assign left_key = key_r;
        assign left_lt  = 1'b1;
      end else begin : g_inner
        assign left_key = key_v[g-1];
        assign left_lt  = lt_v[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign right_key = key_v[g];
      end else begin : g_body
        assign right_key = key_v[g+1];
      end

      skset_cell #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .IDX       (g)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_r),
        .cmp_key   (in_key_w),
        .ins_key   (key_r),
        .left_key  (left_key),
        .left_lt   (left_lt),
        .right_key (right_key),
        .key_q     (key_v[g]),
        .lt_q      (lt_v[g]),
        .eq_q      (eq_v[g]),
        .pick_key  (pick_v[g])
      );
    end
  endgenerate

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_removed_key = out_removed_key_r;
  assign out_occupancy   = out_occupancy_r;

  `SKS_ASSERT_NEXT(a_accept_busy, accept, busy)
  `SKS_ASSERT_NEXT(a_busy_result, busy, out_valid && !busy)
  `SKS_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH))
  `SKS_ASSERT_IMPL(a_single_match, busy, $onehot0(eq_v))

endmodule
